// ----- rtl/ohlc_bar_aggregator_assert.svh -----
// Assertion macros shared by the OHLC bar aggregator RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef OHLC_BAR_AGGREGATOR_ASSERT_SVH
`define OHLC_BAR_AGGREGATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define OHLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition is followed in the next cycle by a consequence.
`define OHLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OHLC_ASSERT(lbl, prop, msg)
`define OHLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/ohlc_pkg.sv -----
// Shared types and constants for the OHLC bar aggregator.
// No dependencies; used by ohlc_cell, ohlc_div and ohlc_bar_aggregator.
`default_nettype none

package ohlc_pkg;

	localparam int PRICE_W = 32;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	// operation codes carried in tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_DURATION = 2'd1;

	localparam logic [CFG_W-1:0] MIN_GAP_RST      = 17'd60;
	localparam logic [CFG_W-1:0] BAR_DURATION_RST = 17'd300;

	localparam logic [PRICE_W-1:0] EMPTY_HIGH_CENTS = 32'd10000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_SCAN,
		ST_OUT
	} state_t;

	// per-cycle command to the bar chain
	typedef struct packed {
		logic shift;   // push: every slot takes its newer-side neighbor
		logic wr;      // rewrite high/low of the newest slot
		logic clr;     // drop all bars
	} cell_ctrl_t;

	// running extremes passed along the chain
	typedef struct packed {
		logic [PRICE_W-1:0] min_v;
		logic [PRICE_W-1:0] max_v;
	} minmax_t;

endpackage

`default_nettype wire

// ----- rtl/ohlc_cell.sv -----
// One bar slot of the OHLC chain: high, low, valid plus one scan stage.
// Depends on ohlc_pkg.
`default_nettype none

module ohlc_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ohlc_pkg::cell_ctrl_t ctrl,
	input  wire logic [31:0]         prev_high,
	input  wire logic [31:0]         prev_low,
	input  wire logic                prev_valid,
	output logic [31:0]              high,
	output logic [31:0]              low,
	output logic                     valid,
	input  wire ohlc_pkg::minmax_t   scan_in,
	output ohlc_pkg::minmax_t        scan_out
);
	import ohlc_pkg::*;

	logic [PRICE_W-1:0] high_q;
	logic [PRICE_W-1:0] low_q;
	logic               valid_q;
	minmax_t            scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift || ctrl.wr) begin
			high_q <= prev_high;
			low_q  <= prev_low;
		end
	end

	// fold this slot into the running extremes when it holds a bar
	always_ff @(posedge clk) begin
		if (valid_q) begin
			scan_q.min_v <= (low_q < scan_in.min_v) ? low_q : scan_in.min_v;
			scan_q.max_v <= (high_q > scan_in.max_v) ? high_q : scan_in.max_v;
		end else begin
			scan_q <= scan_in;
		end
	end

	assign high     = high_q;
	assign low      = low_q;
	assign valid    = valid_q;
	assign scan_out = scan_q;

endmodule

`default_nettype wire

// ----- rtl/ohlc_div.sv -----
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 17-bit divisor.
// Depends on ohlc_pkg.
`default_nettype none

module ohlc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [16:0] divisor,
	output logic             busy,
	output logic [31:0]      quotient
);
	import ohlc_pkg::*;

	localparam int STEPS = TIME_W;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic [STEP_W-1:0] cnt_q;
	logic [CFG_W-1:0]  rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [CFG_W:0]    sh;
	logic [CFG_W:0]    diff;
	logic              ge;

	always_comb begin
		sh   = {rem_q, quo_q[TIME_W-1]};
		diff = sh - {1'b0, divisor};
		ge   = (sh >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEP_W'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift dividend bits out the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[CFG_W-1:0] : sh[CFG_W-1:0];
			quo_q <= {quo_q[TIME_W-2:0], ge};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/ohlc_bar_aggregator.sv -----
// Top level of the OHLC bar aggregator: control sequencer, newest-bar registers,
// bucket dividers and the chain of bar slots. Depends on ohlc_pkg, ohlc_cell,
// ohlc_div and ohlc_bar_aggregator_assert.svh.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------
//  s_*      | in        | s_tvalid / s_tready | s_tuser operation, s_tdata tick/bar
//  m_*      | out       | m_tvalid / m_tready | m_tdata one result per item
//  cfg_*    | in        | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// An item passes from its transfer through the execute step, the bucket divider for a tick
// that has to compare buckets, the scan of window extremes along the chain of BAR_SLOTS
// slots and the output step to its result; the bucket divider works in 32 steps.
// After reset the ring is empty, the minimum tick gap is 60 and bar_duration is 300.
// A finished result sits in the output register until taken; the next item is
// accepted meanwhile and waits in the last step only if the register is still full.
`default_nettype none
`include "ohlc_bar_aggregator_assert.svh"

module ohlc_bar_aggregator #(
	parameter  int BAR_SLOTS = 64,
	localparam int CNT_W     = $clog2(BAR_SLOTS + 1),
	localparam int OUT_BITS  = 2 + 7 * 32 + CNT_W,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// slave stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// s_tdata, low to high: time_sec, price_cents, load_high, load_low, load_close
	input  wire logic [159:0]      s_tdata,
	// s_tuser: operation
	input  wire logic [1:0]        s_tuser,
	// master stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// m_tdata, low to high: accepted, new_bar, bar_open, bar_high, bar_low,
	// bar_close, bar_count, last_price, window_low, window_high, zero fill
	output logic [OUT_W-1:0]       m_tdata,
	// configuration writes
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [16:0]       cfg_data
);
	import ohlc_pkg::*;

	localparam int SCAN_W = (BAR_SLOTS > 1) ? $clog2(BAR_SLOTS) : 1;

	state_t state_q, state_nxt;

	// captured item
	logic [1:0]         op_q;
	logic [TIME_W-1:0]  t_q;
	logic [PRICE_W-1:0] price_q;
	logic [PRICE_W-1:0] ldh_q;
	logic [PRICE_W-1:0] ldl_q;
	logic [PRICE_W-1:0] ldc_q;

	// configuration
	logic [CFG_W-1:0] upd_int_q;
	logic [CFG_W-1:0] dur_q;

	// ring bookkeeping and newest-bar fields kept outside the chain
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  last_upd_q;
	logic [PRICE_W-1:0] recent_q;
	logic [PRICE_W-1:0] nw_open_q;
	logic [PRICE_W-1:0] nw_close_q;
	logic [TIME_W-1:0]  nw_time_q;

	logic accepted_q;
	logic new_bar_q;
	logic [SCAN_W-1:0] scan_cnt_q;

	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	// decoded actions
	logic in_xfer;
	logic take_tick;
	logic push_tick;
	logic push_load;
	logic do_push;
	logic do_upd;
	logic do_clear;
	logic div_start;
	logic out_load;

	logic [TIME_W:0]   diff33;
	logic              rate_ok;
	logic [CFG_W-1:0]  dur_eff;
	logic              div_busy_a, div_busy_b;
	logic [TIME_W-1:0] quo_a, quo_b;
	logic              same_bucket;

	// chain wiring
	logic [PRICE_W-1:0] high_w [BAR_SLOTS];
	logic [PRICE_W-1:0] low_w  [BAR_SLOTS];
	logic [BAR_SLOTS-1:0] valid_w;
	minmax_t            scan_w [BAR_SLOTS];
	minmax_t            scan_seed;
	cell_ctrl_t         ctrl_head;
	cell_ctrl_t         ctrl_tail;
	logic [PRICE_W-1:0] d_high;
	logic [PRICE_W-1:0] d_low;

	logic               empty;
	logic [OUT_BITS-1:0] result;

	assign in_xfer   = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// signed elapsed time against the minimum update interval
	always_comb begin
		diff33      = {1'b0, t_q} - {1'b0, last_upd_q};
		rate_ok     = !diff33[TIME_W] && (diff33[TIME_W-1:0] >= TIME_W'(upd_int_q));
		dur_eff     = (dur_q == '0) ? CFG_W'(1) : dur_q;
		same_bucket = (quo_a == quo_b);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_xfer) state_nxt = ST_EXEC;
			ST_EXEC: state_nxt = div_start ? ST_DIV : ST_SCAN;
			ST_DIV:  if (!(div_busy_a || div_busy_b)) state_nxt = ST_SCAN;
			ST_SCAN: if (scan_cnt_q == '0) state_nxt = ST_OUT;
			ST_OUT:  if (out_load) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// actions per state
	always_comb begin
		take_tick = 1'b0;
		push_tick = 1'b0;
		push_load = 1'b0;
		do_upd    = 1'b0;
		do_clear  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_EXEC: begin
				case (op_q)
					OP_TICK: begin
						if (rate_ok) begin
							take_tick = 1'b1;
							if (price_q != '0) begin
								if (cnt_q == '0) push_tick = 1'b1;
								else div_start = 1'b1;
							end
						end
					end
					OP_LOAD:  push_load = 1'b1;
					OP_CLEAR: do_clear  = 1'b1;
					default: ;
				endcase
			end
			ST_DIV: begin
				if (!(div_busy_a || div_busy_b)) begin
					if (same_bucket) do_upd = 1'b1;
					else push_tick = 1'b1;
				end
			end
			ST_OUT: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	assign do_push = push_tick || push_load;

	// data for the newest slot: a fresh bar or the widened current one
	always_comb begin
		if (push_load) begin
			d_high = ldh_q;
			d_low  = ldl_q;
		end else if (push_tick) begin
			d_high = price_q;
			d_low  = price_q;
		end else begin
			d_high = (price_q > high_w[0]) ? price_q : high_w[0];
			d_low  = (price_q < low_w[0]) ? price_q : low_w[0];
		end
	end

	assign ctrl_head = '{shift: do_push, wr: do_upd, clr: do_clear};
	assign ctrl_tail = '{shift: do_push, wr: 1'b0, clr: do_clear};
	assign scan_seed = '{min_v: '1, max_v: '0};

	for (genvar i = 0; i < BAR_SLOTS; i++) begin : g_slot
		if (i == 0) begin : g_head
			ohlc_cell u_slot (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl_head),
				.prev_high (d_high),
				.prev_low  (d_low),
				.prev_valid(1'b1),
				.high      (high_w[i]),
				.low       (low_w[i]),
				.valid     (valid_w[i]),
				.scan_in   (scan_seed),
				.scan_out  (scan_w[i])
			);
		end else begin : g_tail
			ohlc_cell u_slot (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl_tail),
				.prev_high (high_w[i-1]),
				.prev_low  (low_w[i-1]),
				.prev_valid(valid_w[i-1]),
				.high      (high_w[i]),
				.low       (low_w[i]),
				.valid     (valid_w[i]),
				.scan_in   (scan_w[i-1]),
				.scan_out  (scan_w[i])
			);
		end
	end

	// bucket numbers of the tick and of the newest bar
	ohlc_div u_div_tick (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(t_q),
		.divisor (dur_eff),
		.busy    (div_busy_a),
		.quotient(quo_a)
	);

	ohlc_div u_div_bar (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(nw_time_q),
		.divisor (dur_eff),
		.busy    (div_busy_b),
		.quotient(quo_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// capture the item on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= s_tuser;
			t_q     <= s_tdata[31:0];
			price_q <= s_tdata[63:32];
			ldh_q   <= s_tdata[95:64];
			ldl_q   <= s_tdata[127:96];
			ldc_q   <= s_tdata[159:128];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_int_q <= MIN_GAP_RST;
			dur_q     <= BAR_DURATION_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_GAP:      upd_int_q <= cfg_data;
				REG_BAR_DURATION: dur_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ring fill: saturate at the slot count, drop to zero on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (do_clear) begin
			cnt_q <= '0;
		end else if (do_push && (cnt_q < CNT_W'(BAR_SLOTS))) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_upd_q <= '0;
			recent_q   <= '0;
		end else if (take_tick) begin
			last_upd_q <= t_q;
			recent_q   <= price_q;
		end else if (push_load) begin
			recent_q   <= price_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			nw_open_q  <= price_q;
			nw_time_q  <= t_q;
			nw_close_q <= push_load ? ldc_q : price_q;
		end else if (do_upd) begin
			nw_close_q <= price_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= 1'b0;
			new_bar_q  <= 1'b0;
		end else if (in_xfer) begin
			accepted_q <= 1'b0;
			new_bar_q  <= 1'b0;
		end else begin
			if (take_tick && (price_q != '0)) accepted_q <= 1'b1;
			if (do_push) new_bar_q <= 1'b1;
		end
	end

	// hold the scan for one full pass of the chain after the last change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= SCAN_W'(BAR_SLOTS - 1);
		end else if (state_q == ST_SCAN) begin
			scan_cnt_q <= scan_cnt_q - 1'b1;
		end else begin
			scan_cnt_q <= SCAN_W'(BAR_SLOTS - 1);
		end
	end

	assign empty = (cnt_q == '0);

	always_comb begin
		result = {
			empty ? EMPTY_HIGH_CENTS : scan_w[BAR_SLOTS-1].max_v,
			empty ? '0 : scan_w[BAR_SLOTS-1].min_v,
			recent_q,
			cnt_q,
			empty ? '0 : nw_close_q,
			empty ? '0 : low_w[0],
			empty ? '0 : high_w[0],
			empty ? '0 : nw_open_q,
			new_bar_q,
			accepted_q
		};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= OUT_W'(result);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`OHLC_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(BAR_SLOTS), "bar count above slot count")
	`OHLC_ASSERT(a_valid_match, $countones(valid_w) == int'(cnt_q), "valid slots differ from count")
	`OHLC_ASSERT_NEXT(a_push_count, do_push && (cnt_q < CNT_W'(BAR_SLOTS)), cnt_q == $past(cnt_q) + CNT_W'(1), "push did not grow count")
	`OHLC_ASSERT(a_acc_tick, !accepted_q || (op_q == OP_TICK), "accepted flag set for non-tick")

endmodule

`default_nettype wire

// ----- tb/ohlc_bar_aggregator_tb.sv -----
// Self-checking testbench for ohlc_bar_aggregator: streams ticks, bar loads and clears,
// predicts each result with a behavioral bar ring and compares it field by field.
// Depends on ohlc_pkg and the ohlc_bar_aggregator RTL.

module ohlc_bar_aggregator_tb;
	import ohlc_pkg::*;

	localparam int BAR_SLOTS = 64;
	localparam int RESULT_W  = 240;
	// slowest item: chain scan plus the bucket divider
	localparam int LATENCY   = BAR_SLOTS + 36;
	localparam int LONG_HOLD = 600;
	// operation code three is unused by the block and must leave the state alone
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic        accepted;
		logic        new_bar;
		logic [31:0] bar_open;
		logic [31:0] bar_high;
		logic [31:0] bar_low;
		logic [31:0] bar_close;
		logic [6:0]  bar_count;
		logic [31:0] last_price;
		logic [31:0] window_low;
		logic [31:0] window_high;
	} bar_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// low to high: time_sec, price_cents, load_high, load_low, load_close
	logic [159:0]        s_tdata = '0;
	// operation
	logic [1:0]          s_tuser = OP_TICK;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// low to high: accepted, new_bar, bar_open, bar_high, bar_low, bar_close,
	// bar_count, last_price, window_low, window_high, zero fill
	logic [RESULT_W-1:0] m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = REG_MIN_GAP;
	logic [16:0]         cfg_data = '0;

	// behavioral copy of the bar ring and its registers
	logic [31:0] ring_open  [BAR_SLOTS];
	logic [31:0] ring_high  [BAR_SLOTS];
	logic [31:0] ring_low   [BAR_SLOTS];
	logic [31:0] ring_close [BAR_SLOTS];
	logic [31:0] ring_stamp [BAR_SLOTS];
	logic [5:0]  head_slot = 6'(BAR_SLOTS - 1);
	int          ring_fill = 0;
	logic [31:0] last_tick_sec = '0;
	logic [31:0] last_px = '0;
	logic [16:0] cfg_interval = MIN_GAP_RST;
	logic [16:0] cfg_duration = BAR_DURATION_RST;

	bar_result_t pending_bars[$];
	int          mismatch_count = 0;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	int          hold_left = 0;

	ohlc_bar_aggregator #(.BAR_SLOTS(BAR_SLOTS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void ring_push(input logic [31:0] px, input logic [31:0] t);
		if (ring_fill < BAR_SLOTS)
			ring_fill++;
		head_slot = head_slot + 6'd1;
		ring_open[head_slot]  = px;
		ring_high[head_slot]  = px;
		ring_low[head_slot]   = px;
		ring_close[head_slot] = px;
		ring_stamp[head_slot] = t;
		last_px = px;
	endfunction

	// Advance the ring by one item and return the result the block should report.
	function automatic bar_result_t predict_bar(input logic [1:0] op, input logic [31:0] t,
			input logic [31:0] px, input logic [31:0] hi, input logic [31:0] lo,
			input logic [31:0] cl);
		bar_result_t r;
		longint      waited;
		logic [31:0] span;
		int          k;
		r = '{default: '0};
		case (op)
			OP_TICK: begin
				waited = longint'(t) - longint'(last_tick_sec);
				if (waited >= longint'(cfg_interval)) begin
					// the update time and price move on even for a zero price
					last_tick_sec = t;
					last_px = px;
					if (px != 0) begin
						span = (cfg_duration == 0) ? 32'd1 : 32'(cfg_duration);
						r.accepted = 1'b1;
						if (ring_fill == 0 || t / span != ring_stamp[head_slot] / span) begin
							ring_push(px, t);
							r.new_bar = 1'b1;
						end else begin
							ring_close[head_slot] = px;
							if (px > ring_high[head_slot])
								ring_high[head_slot] = px;
							if (px < ring_low[head_slot])
								ring_low[head_slot] = px;
						end
					end
				end
			end
			OP_LOAD: begin
				ring_push(px, t);
				ring_close[head_slot] = cl;
				ring_high[head_slot]  = hi;
				ring_low[head_slot]   = lo;
				r.new_bar = 1'b1;
			end
			OP_CLEAR: begin
				ring_fill = 0;
				head_slot = 6'(BAR_SLOTS - 1);
			end
			default: ;
		endcase
		if (ring_fill > 0) begin
			r.window_low  = '1;
			r.window_high = '0;
			for (int i = 0; i < ring_fill; i++) begin
				k = (int'(head_slot) + BAR_SLOTS + 1 + i - ring_fill) % BAR_SLOTS;
				if (ring_low[k] < r.window_low)
					r.window_low = ring_low[k];
				if (ring_high[k] > r.window_high)
					r.window_high = ring_high[k];
			end
			r.bar_open  = ring_open[head_slot];
			r.bar_high  = ring_high[head_slot];
			r.bar_low   = ring_low[head_slot];
			r.bar_close = ring_close[head_slot];
		end else begin
			r.window_low  = '0;
			r.window_high = EMPTY_HIGH_CENTS;
		end
		r.bar_count  = ring_fill[6:0];
		r.last_price = last_px;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch in %s: expected %h, got %h", name, want, got);
		end
	endfunction

	// Offer one item, hold it until the transfer, then queue its expected result.
	task automatic send_item(input logic [1:0] op, input logic [31:0] t, input logic [31:0] px,
			input logic [31:0] hi, input logic [31:0] lo, input logic [31:0] cl);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {cl, lo, hi, px, t};
		do @(posedge clk); while (!s_tready);
		pending_bars.push_back(predict_bar(op, t, px, hi, lo, cl));
	endtask

	// Drop valid and wait until every result is back and the block has gone quiet.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_bars.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MIN_GAP)
			cfg_interval = val;
		else if (idx == REG_BAR_DURATION)
			cfg_duration = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Rate limit, zero price, bucket update vs. new bar, loads, clears and the spare code,
	// all at the reset settings and with small tick times.
	task automatic test_directed();
		send_item(OP_SPARE, '1, '1, '1, '1, '1);
		send_item(OP_TICK, 32'd0, 32'd100, '0, '0, '0);
		send_item(OP_TICK, 32'd60, 32'd0, '0, '0, '0);
		send_item(OP_TICK, 32'd100, 32'd500, '0, '0, '0);
		send_item(OP_TICK, 32'd120, 32'd500, '0, '0, '0);
		send_item(OP_TICK, 32'd180, 32'd900, '0, '0, '0);
		send_item(OP_TICK, 32'd240, 32'd200, '0, '0, '0);
		send_item(OP_TICK, 32'd300, '1, '0, '0, '0);
		send_item(OP_TICK, 32'd400, 32'd1, '0, '0, '0);
		// low above high is stored as given
		send_item(OP_LOAD, 32'd500, '1, '0, '1, '0);
		send_item(OP_LOAD, '0, '0, '0, '0, '0);
		send_item(OP_LOAD, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555);
		send_item(OP_LOAD, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA);
		send_item(OP_TICK, 32'd460, 32'd7, '0, '0, '0);
		send_item(OP_SPARE, '0, '0, '0, '0, '0);
		send_item(OP_CLEAR, '0, '0, '0, '0, '0);
		send_item(OP_TICK, 32'd520, 32'd3, '0, '0, '0);
		send_item(OP_CLEAR, '1, '1, '1, '1, '1);
		send_item(OP_CLEAR, '0, '0, '0, '0, '0);
		drain_results();
	endtask

	// Mostly well-formed tick streams above floor_sec, mixed with rate-limited and
	// backward ticks, loads, clears and the spare code.
	task automatic test_random_traffic(input int n_items, input logic [16:0] interval,
			input logic [16:0] duration, input logic [31:0] floor_sec, input int clear_permil);
		int          counted;
		int          pick;
		logic [31:0] span;
		logic [31:0] base;
		logic [31:0] walk_px;
		logic [31:0] back;
		logic [1:0]  op;
		logic [31:0] t, px, hi, lo, cl;
		drain_results();
		write_reg(REG_MIN_GAP, interval);
		write_reg(REG_BAR_DURATION, duration);
		span = (duration == 0) ? 32'd1 : 32'(duration);
		walk_px = $urandom_range(1000, 1000000);
		counted = 0;
		while (counted < n_items) begin
			base = (last_tick_sec < floor_sec) ? floor_sec : last_tick_sec;
			hi = $urandom;
			lo = $urandom;
			cl = $urandom;
			case ($urandom_range(9))
				0: px = '0;
				1, 2: px = $urandom;
				3: px = $urandom_range(1, 16);
				default: begin
					walk_px = walk_px + $urandom_range(0, 200) - 100;
					px = walk_px;
				end
			endcase
			pick = $urandom_range(99);
			if ($urandom_range(999) < clear_permil) begin
				op = OP_CLEAR;
				t = $urandom;
			end else if (pick < 62) begin
				op = OP_TICK;
				t = base + interval + $urandom_range(0, 2 * span);
			end else if (pick < 72) begin
				op = OP_TICK;
				t = last_tick_sec + ((interval == 0) ? 0 : $urandom_range(0, interval - 1));
			end else if (pick < 77) begin
				op = OP_TICK;
				back = (last_tick_sec < 1000) ? last_tick_sec : 32'd1000;
				t = last_tick_sec - $urandom_range(0, back);
			end else if (pick < 95) begin
				op = OP_LOAD;
				t = ($urandom_range(3) == 0) ? $urandom : base + $urandom_range(0, 2 * span);
				if ($urandom_range(1)) begin
					// a plausible bar around the open
					hi = px + $urandom_range(0, 500);
					lo = px - $urandom_range(0, 500);
				end
			end else begin
				op = OP_SPARE;
				t = $urandom;
			end
			send_item(op, t, px, hi, lo, cl);
			if (op != OP_SPARE)
				counted++;
		end
		drain_results();
	endtask

	// Hold off the receiver for a long stretch while loads keep coming, so the
	// block fills up and stalls its input.
	task automatic test_output_stall();
		@(posedge clk);
		hold_left = LONG_HOLD;
		for (int k = 0; k < 24; k++)
			send_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
		drain_results();
	endtask

	// Times at the top of the range; run last since the update time cannot go back.
	task automatic test_time_extremes();
		write_reg(REG_MIN_GAP, MIN_GAP_RST);
		write_reg(REG_BAR_DURATION, BAR_DURATION_RST);
		send_item(OP_TICK, '1, 32'd7, '0, '0, '0);
		send_item(OP_TICK, '0, 32'd8, '0, '0, '0);
		send_item(OP_TICK, '1, 32'd0, '0, '0, '0);
		send_item(OP_SPARE, '1, '1, '1, '1, '1);
		send_item(OP_CLEAR, '0, '0, '0, '0, '0);
		drain_results();
	endtask

	// Receiver: random stalls, or a counted long hold when one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		bar_result_t got;
		bar_result_t want;
		if (m_tvalid && m_tready) begin
			got.accepted    = m_tdata[0];
			got.new_bar     = m_tdata[1];
			got.bar_open    = m_tdata[2 +: 32];
			got.bar_high    = m_tdata[34 +: 32];
			got.bar_low     = m_tdata[66 +: 32];
			got.bar_close   = m_tdata[98 +: 32];
			got.bar_count   = m_tdata[130 +: 7];
			got.last_price  = m_tdata[137 +: 32];
			got.window_low  = m_tdata[169 +: 32];
			got.window_high = m_tdata[201 +: 32];
			if (pending_bars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with nothing expected: %h", m_tdata);
			end else begin
				want = pending_bars.pop_front();
				check_field("accepted", want.accepted, got.accepted);
				check_field("new_bar", want.new_bar, got.new_bar);
				check_field("bar_open", want.bar_open, got.bar_open);
				check_field("bar_high", want.bar_high, got.bar_high);
				check_field("bar_low", want.bar_low, got.bar_low);
				check_field("bar_close", want.bar_close, got.bar_close);
				check_field("bar_count", want.bar_count, got.bar_count);
				check_field("last_price", want.last_price, got.last_price);
				check_field("window_low", want.window_low, got.window_low);
				check_field("window_high", want.window_high, got.window_high);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();

		src_idle_pct = 29;
		snk_idle_pct = 77;
		// no clears here, so the ring wraps and overwrites its oldest bars
		test_random_traffic(300, 17'd0, 17'd1, 32'h0000_1000, 0);
		test_random_traffic(300, 17'd60, 17'd300, 32'h1000_0000, 40);

		src_idle_pct = 77;
		snk_idle_pct = 29;
		test_random_traffic(300, 17'h1FFFF, 17'h1FFFF, 32'h3000_0000, 5);
		test_random_traffic(300, 17'd5, 17'd86400, 32'h5000_0000, 5);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		// a zero bar duration counts as one second
		test_random_traffic(300, 17'd0, 17'd0, 32'h7000_0000, 0);
		test_random_traffic(300, 17'($urandom_range(0, 200)), 17'($urandom_range(1, 1000)),
			32'h9000_0000, 10);
		test_output_stall();
		test_time_extremes();

		if (mismatch_count == 0 && pending_bars.size() == 0)
			$display("ohlc_bar_aggregator_tb OK");
		else
			$display("ohlc_bar_aggregator_tb NOT OK");
		$finish;
	end

	initial begin
		#4000000;
		$display("ohlc_bar_aggregator_tb NOT OK");
		$finish;
	end

endmodule
